// ===== rtl/mrh_pkg.sv =====
// ----------------------------------------------------------------------------
// mrh_pkg
// Shared constants, types and helpers of the min-rooms heap tracker.
// ----------------------------------------------------------------------------
package mrh_pkg;

  localparam int HEAP_DEPTH = 1024;
  localparam int ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int IDX_W      = ADDR_W + 2;
  localparam int VAL_W      = 32;
  localparam int ROOMS_W    = 11;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [ROOMS_W-1:0]      rooms_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DOWN,
    ST_UP,
    ST_DONE
  } state_t;

  typedef struct packed {
    val_t start_time;
    val_t end_time;
    logic new_set;
  } req_t;

  typedef struct packed {
    cnt_t count;
    logic overflow;
  } res_t;

  // entry count shown on the result, saturated to the field width
  function automatic rooms_t rooms_of(cnt_t c);
    localparam int WIDE_W = CNT_W + ROOMS_W;
    logic [WIDE_W-1:0] wide;
    logic [WIDE_W-1:0] top;
    wide = {{ROOMS_W{1'b0}}, c};
    top  = {{CNT_W{1'b0}}, {ROOMS_W{1'b1}}};
    if (wide > top) begin
      return {ROOMS_W{1'b1}};
    end
    return wide[ROOMS_W-1:0];
  endfunction

endpackage

// ===== rtl/mrh_in_if.sv =====
// ----------------------------------------------------------------------------
// mrh_in_if
// Interval channel: valid/ready handshake with start, end and new-set flag.
// ----------------------------------------------------------------------------
interface mrh_in_if import mrh_pkg::*; ();
  logic valid;
  logic ready;
  val_t start_time;
  val_t end_time;
  logic new_set;

  modport source (output valid, output start_time, output end_time, output new_set,
                  input ready);
  modport sink   (input valid, input start_time, input end_time, input new_set,
                  output ready);
endinterface

// ===== rtl/mrh_out_if.sv =====
// ----------------------------------------------------------------------------
// mrh_out_if
// Result channel: valid/ready handshake with room count and overflow flag.
// ----------------------------------------------------------------------------
interface mrh_out_if import mrh_pkg::*; ();
  logic   valid;
  logic   ready;
  rooms_t rooms_needed;
  logic   overflow;

  modport source (output valid, output rooms_needed, output overflow, input ready);
  modport sink   (input valid, input rooms_needed, input overflow, output ready);
endinterface

// ===== rtl/mrh_heap_core.sv =====
// ----------------------------------------------------------------------------
// mrh_heap_core
// Min-heap of end times in a one-write, two-read synchronous memory. A reused
// room replaces the root and sifts down; a new room sifts up from the tail.
// The moving value is held in a register and only the hole is written.
// ----------------------------------------------------------------------------
module mrh_heap_core import mrh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  val_t   mem [HEAP_DEPTH];

  state_t state, state_next;
  cnt_t   count, count_next;
  val_t   root, root_next;
  addr_t  hole, hole_next;
  val_t   val, val_next;
  logic   ovf, ovf_next;

  logic   we;
  addr_t  wa;
  val_t   wd;
  addr_t  ra, rb;
  val_t   qa, qb;

  cnt_t   cnt0;
  addr_t  tail;
  logic   pop;
  idx_t   l_idx, r_idx, c_idx, cl_idx, cr_idx;
  logic   l_ok, r_ok, pick_r;
  val_t   cval;
  addr_t  par, gpar, tail_par;

  // heap storage
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    qa <= mem[ra];
    qb <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    root <= root_next;
    hole <= hole_next;
    val  <= val_next;
    ovf  <= ovf_next;
  end

  always_comb begin
    state_next = state;
    count_next = count;
    root_next  = root;
    hole_next  = hole;
    val_next   = val;
    ovf_next   = ovf;

    cnt0     = req.new_set ? '0 : count;
    tail     = cnt0[ADDR_W-1:0];
    tail_par = (tail - addr_t'(1)) >> 1;
    pop      = (cnt0 != '0) && (req.start_time >= root);

    l_idx  = {1'b0, hole, 1'b1};
    r_idx  = l_idx + idx_t'(1);
    l_ok   = l_idx < idx_t'(count);
    r_ok   = r_idx < idx_t'(count);
    pick_r = r_ok && (qb < qa);
    cval   = pick_r ? qb : qa;
    c_idx  = pick_r ? r_idx : l_idx;
    cl_idx = {c_idx[IDX_W-2:0], 1'b1};
    cr_idx = cl_idx + idx_t'(1);

    par  = (hole - addr_t'(1)) >> 1;
    gpar = (par - addr_t'(1)) >> 1;

    we = 1'b0;
    wa = hole;
    wd = val;
    ra = cl_idx[ADDR_W-1:0];
    rb = cr_idx[ADDR_W-1:0];

    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          val_next = req.end_time;
          ovf_next = 1'b0;
          if (pop) begin
            count_next = cnt0;
            hole_next  = '0;
            ra         = addr_t'(1);
            rb         = addr_t'(2 % HEAP_DEPTH);
            state_next = ST_DOWN;
          end else if (cnt0 == cnt_t'(HEAP_DEPTH)) begin
            count_next = cnt0;
            ovf_next   = 1'b1;
            state_next = ST_DONE;
          end else begin
            count_next = cnt0 + cnt_t'(1);
            hole_next  = tail;
            ra         = tail_par;
            if (cnt0 == '0) begin
              we         = 1'b1;
              wa         = '0;
              wd         = req.end_time;
              state_next = ST_DONE;
            end else begin
              state_next = ST_UP;
            end
          end
        end
      end
      ST_DOWN: begin
        we = 1'b1;
        if (l_ok && (cval < val)) begin
          wd        = cval;
          hole_next = c_idx[ADDR_W-1:0];
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_UP: begin
        we = 1'b1;
        ra = gpar;
        if ((hole != '0) && (qa > val)) begin
          wd        = qa;
          hole_next = par;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (we && (wa == '0)) begin
      root_next = wd;
    end
  end

  assign req_ready    = (state == ST_IDLE);
  assign res_valid    = (state == ST_DONE);
  assign res.count    = count;
  assign res.overflow = ovf;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(HEAP_DEPTH))
    else $error("entry count beyond heap depth");

  a_down_hole: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DOWN) |-> (idx_t'(hole) < idx_t'(count)))
    else $error("sift-down hole outside the heap");

  a_up_hole: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UP) |-> (idx_t'(hole) < idx_t'(count)))
    else $error("sift-up hole outside the heap");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && ovf) |-> (count == cnt_t'(HEAP_DEPTH)))
    else $error("overflow reported on a heap that is not full");

  a_sift_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DOWN || state == ST_UP) |=> (count != '0))
    else $error("sift running on an empty heap");

endmodule

// ===== rtl/min_rooms_heap_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// min_rooms_heap_tracker_unit
// Running room count for intervals in start order, kept as a min-heap of
// end times; one result transaction per interval transaction.
// ----------------------------------------------------------------------------
//  channel    | dir | payload                              | handshake
//  intervals  | in  | start_time, end_time, new_set        | valid/ready
//  results    | out | rooms_needed, overflow               | valid/ready
//
//  one interval at a time: the hole moves one level per write of the single
//  heap write port; a first entry or a dropped insert does not sift
//  reset clears the state and entry count only; heap memory is never cleared
//  results sit in an output register, so the next interval is taken while
//  a result waits; the engine holds its result if that register stays full
// ----------------------------------------------------------------------------
module min_rooms_heap_tracker_unit import mrh_pkg::*; (
  input logic      clk,
  input logic      rst,
  mrh_in_if.sink   intervals,
  mrh_out_if.source results
);

  req_t   req;
  res_t   res;
  logic   res_valid;
  logic   res_ready;
  logic   out_valid;
  rooms_t out_rooms;
  logic   out_ovf;

  assign req.start_time = intervals.start_time;
  assign req.end_time   = intervals.end_time;
  assign req.new_set    = intervals.new_set;

  mrh_heap_core u_core (
    .clk       (clk),
    .rst       (rst),
    .req_valid (intervals.valid),
    .req_ready (intervals.ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_rooms <= rooms_of(res.count);
      out_ovf   <= res.overflow;
    end
  end

  assign results.valid        = out_valid;
  assign results.rooms_needed = out_rooms;
  assign results.overflow     = out_ovf;

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives interval transactions into the min-rooms heap tracker and checks each
// result transaction against a min-heap of end times kept in the bench itself.
// Covers boundary values, equal start/end reuse, out-of-order starts, set
// clears, a full heap with dropped inserts, and random sets with idle cycles.
// ----------------------------------------------------------------------------
module testbench import mrh_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CYCLE_LIMIT = 400000;
  localparam int     QUIET_START = 3000;
  localparam int     QUIET_END   = 8000;
  localparam int     RANDOM_ITEMS = 550;
  localparam longint VAL_MIN     = -64'sd2147483648;
  localparam longint VAL_MAX     = 64'sd2147483647;

  typedef struct packed {
    rooms_t rooms_needed;
    logic   overflow;
  } rooms_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mrh_in_if  intervals ();
  mrh_out_if results ();

  min_rooms_heap_tracker_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .intervals (intervals),
    .results   (results)
  );

  req_t       interval_q[$];
  rooms_res_t rooms_expect_q[$];
  val_t       end_heap[HEAP_DEPTH];
  int         heap_fill = 0;

  int   cyc = 0;
  int   mismatches = 0;
  int   sent = 0;
  int   checked = 0;
  int   overflow_seen = 0;
  int   peak_rooms = 0;
  logic in_fire = 1'b0;

  always #4 clk = ~clk;

  // next room count after one interval: free the earliest room if it ended, then book one unless the heap is full
  function automatic rooms_res_t rooms_after(req_t r);
    int         pos;
    int         best;
    int         kid;
    val_t       tmp;
    rooms_res_t res;
    res.overflow = 1'b0;
    if (r.new_set) begin
      heap_fill = 0;
    end
    if (heap_fill > 0 && $signed(r.start_time) >= $signed(end_heap[0])) begin
      heap_fill--;
      end_heap[0] = end_heap[heap_fill];
      pos = 0;
      forever begin
        best = pos;
        kid  = 2 * pos + 1;
        if (kid < heap_fill && $signed(end_heap[kid]) < $signed(end_heap[best])) begin
          best = kid;
        end
        if (kid + 1 < heap_fill && $signed(end_heap[kid + 1]) < $signed(end_heap[best])) begin
          best = kid + 1;
        end
        if (best == pos) break;
        tmp            = end_heap[best];
        end_heap[best] = end_heap[pos];
        end_heap[pos]  = tmp;
        pos            = best;
      end
    end
    if (heap_fill >= HEAP_DEPTH) begin
      res.overflow = 1'b1;
    end else begin
      end_heap[heap_fill] = r.end_time;
      pos = heap_fill;
      heap_fill++;
      while (pos > 0 && $signed(end_heap[(pos - 1) / 2]) > $signed(end_heap[pos])) begin
        tmp                      = end_heap[(pos - 1) / 2];
        end_heap[(pos - 1) / 2]  = end_heap[pos];
        end_heap[pos]            = tmp;
        pos                      = (pos - 1) / 2;
      end
    end
    res.rooms_needed = (heap_fill > 2047) ? {ROOMS_W{1'b1}} : rooms_t'(heap_fill);
    return res;
  endfunction

  function automatic bit idle_now();
    if (cyc >= QUIET_START && cyc < QUIET_END) return 1'b0;
    return $urandom_range(99) < 9;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= 30) begin
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cyc, what, got, want);
    end
  endtask

  task automatic push_interval(longint s, longint e, bit ns);
    req_t r;
    if (s < VAL_MIN) s = VAL_MIN;
    if (s > VAL_MAX) s = VAL_MAX;
    if (e < VAL_MIN) e = VAL_MIN;
    if (e > VAL_MAX) e = VAL_MAX;
    r.start_time = val_t'(s);
    r.end_time   = val_t'(e);
    r.new_set    = ns;
    interval_q.push_back(r);
  endtask

  // transaction capture, prediction and result check
  always @(posedge clk) begin
    rooms_res_t want;
    cyc++;
    if (cyc >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cyc, rooms_expect_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      in_fire <= !rst && intervals.valid && intervals.ready;
      if (!rst && intervals.valid && intervals.ready) begin
        want = rooms_after('{intervals.start_time, intervals.end_time, intervals.new_set});
        rooms_expect_q.push_back(want);
        sent++;
        if (want.overflow) overflow_seen++;
        if (int'(want.rooms_needed) > peak_rooms) peak_rooms = int'(want.rooms_needed);
      end
      if (!rst && results.valid && results.ready) begin
        if (rooms_expect_q.size() == 0) begin
          report_mismatch("unexpected result, rooms_needed", int'(results.rooms_needed), -1);
        end else begin
          want = rooms_expect_q.pop_front();
          checked++;
          if (results.rooms_needed !== want.rooms_needed) begin
            report_mismatch("rooms_needed", int'(results.rooms_needed),
                            int'(want.rooms_needed));
          end
          if (results.overflow !== want.overflow) begin
            report_mismatch("overflow", int'(results.overflow), int'(want.overflow));
          end
        end
      end
    end
  end

  // interval driver
  always @(negedge clk) begin
    req_t r;
    if (rst) begin
      intervals.valid <= 1'b0;
    end else if (!intervals.valid || in_fire) begin
      if (interval_q.size() > 0 && !idle_now()) begin
        r = interval_q.pop_front();
        intervals.valid      <= 1'b1;
        intervals.start_time <= r.start_time;
        intervals.end_time   <= r.end_time;
        intervals.new_set    <= r.new_set;
      end else begin
        intervals.valid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    results.ready <= !rst && !idle_now();
  end

  initial begin
    int     rand_items;
    int     n;
    int     pick;
    longint s;
    longint e;

    intervals.valid      = 1'b0;
    intervals.start_time = '0;
    intervals.end_time   = '0;
    intervals.new_set    = 1'b0;
    results.ready        = 1'b0;

    // directed: empty heap after reset, equal reuse, extremes, out of order, clears
    push_interval(0, 10, 1'b0);
    push_interval(10, 20, 1'b0);
    push_interval(15, 25, 1'b0);
    push_interval(VAL_MIN, VAL_MAX, 1'b1);
    push_interval(VAL_MIN, VAL_MIN, 1'b0);
    push_interval(VAL_MIN, 0, 1'b0);
    push_interval(VAL_MAX, VAL_MAX, 1'b0);
    push_interval(VAL_MAX, -1, 1'b0);
    push_interval(-5, 3, 1'b0);
    push_interval(-6, -7, 1'b0);
    push_interval(100, 50, 1'b1);
    push_interval(100, 100, 1'b0);
    push_interval(100, 100, 1'b0);
    push_interval(longint'(32'sh5555_5555), longint'(int'(32'hAAAA_AAAA)), 1'b1);
    push_interval(longint'(int'(32'hAAAA_AAAA)), longint'(32'sh5555_5555), 1'b0);
    push_interval(-1, -1, 1'b1);
    push_interval(0, VAL_MIN, 1'b0);
    push_interval(0, 0, 1'b0);

    // full heap: the loop's starts stay below every end so no room is freed until the VAL_MAX start
    for (int i = 0; i < HEAP_DEPTH + 4; i++) begin
      push_interval(VAL_MIN + i, longint'($urandom_range(32'h7FFF_FFFF, 0)), i == 0);
    end
    push_interval(VAL_MAX, longint'($urandom_range(32'h7FFF_FFFF, 0)), 1'b0);
    push_interval(VAL_MIN, 0, 1'b0);
    push_interval(VAL_MIN, 0, 1'b0);

    // random: mostly ordered sets, some noise and broken order
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if ($urandom_range(9) == 0) begin
        push_interval(longint'(int'($urandom)), longint'(int'($urandom)),
                      $urandom_range(7) == 0);
        rand_items++;
      end else begin
        pick = $urandom_range(7);
        n = (pick == 0) ? $urandom_range(120, 40) : $urandom_range(40, 1);
        case ($urandom_range(5))
          0:       s = VAL_MIN + $urandom_range(300);
          1:       s = VAL_MAX - $urandom_range(300);
          default: s = longint'(int'($urandom));
        endcase
        for (int k = 0; k < n; k++) begin
          if (k > 0) begin
            if ($urandom_range(19) == 0) s = s - $urandom_range(500, 1);
            else s = s + $urandom_range(20);
          end
          if (s < VAL_MIN) s = VAL_MIN;
          if (s > VAL_MAX) s = VAL_MAX;
          case ($urandom_range(9))
            0:       e = s;
            1:       e = s - $urandom_range(1000, 1);
            2:       e = longint'(int'($urandom));
            default: e = s + ((pick == 0) ? $urandom_range(2000, 1) : $urandom_range(80, 1));
          endcase
          push_interval(s, e, k == 0);
        end
        rand_items += n;
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (interval_q.size() != 0 || intervals.valid || rooms_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);

    $display("%0d intervals sent, %0d results checked, %0d with the heap full",
             sent, checked, overflow_seen);
    $display("largest room count %0d, finished at cycle %0d", peak_rooms, cyc);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
